### hdl/assert_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define RBH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// An implication checked at every rising edge outside reset.
`define RBH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/rbh_pkg.sv
`timescale 1ns / 1ps

package rbh_pkg;

	// Fixed widths of the words on the ports.
	localparam int VALUE_W     = 16;
	localparam int BIN_INDEX_W = 6;
	localparam int COUNT_W     = 32;
	localparam int HIT_W       = 7;
	localparam int REG_IDX_W   = 2;

	// Widths that cover the whole parameter range of the chain.
	localparam int IDX_W   = 8;                   // enough for 256 bins
	localparam int LO_W    = VALUE_W + IDX_W + 1; // running bin start
	localparam int TALLY_W = IDX_W + 1;           // counts up to 256 bins

	// Parameter defaults.
	localparam int NUM_BINS_DEF   = 64;
	localparam int VALUE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_RANGE_START = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_END   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BIN_STEP    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH   = 2'd3;

	// Register reset values.
	localparam logic [VALUE_W-1:0] RANGE_START_RST = 16'd0;
	localparam logic [VALUE_W-1:0] RANGE_END_RST   = 16'd255;
	localparam logic [VALUE_W-1:0] BIN_STEP_RST    = 16'd4;
	localparam logic [VALUE_W-1:0] BIN_WIDTH_RST   = 16'd4;

	// Command codes.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic                   op;
		logic [VALUE_W-1:0]     sample_value;
		logic [BIN_INDEX_W-1:0] bin_index;
	} hist_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bin_count;
		logic [VALUE_W-1:0] bin_low;
		logic [VALUE_W-1:0] bin_high;
		logic               bin_exists;
		logic [HIT_W-1:0]   bins_hit;
		logic [COUNT_W-1:0] max_count;
		logic [HIT_W-1:0]   nonzero_bins;
	} hist_out_t;

	// Configuration as seen by every cell; step and width are never zero here.
	typedef struct packed {
		logic [VALUE_W-1:0] range_start;
		logic [VALUE_W-1:0] range_end;
		logic [VALUE_W-1:0] bin_step;
		logic [VALUE_W-1:0] bin_width;
	} cfg_t;

	// Word that travels down the chain, one cell per cycle.
	typedef struct packed {
		logic                   op;
		logic [VALUE_W-1:0]     sample;
		logic [BIN_INDEX_W-1:0] idx;
		logic [LO_W-1:0]        lo;
		logic [TALLY_W-1:0]     hits;
		logic [COUNT_W-1:0]     max_cnt;
		logic [TALLY_W-1:0]     nz;
		logic [COUNT_W-1:0]     rd_count;
		logic [VALUE_W-1:0]     rd_low;
		logic [VALUE_W-1:0]     rd_high;
		logic                   rd_exists;
	} tok_t;

endpackage

### hdl/rbh_cell.sv
`timescale 1ns / 1ps

module rbh_cell #(
	parameter int CELL_IDX   = 0,
	parameter int COUNT_BITS = rbh_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rbh_pkg::cfg_t cfg,
	input  logic          in_vld,
	input  rbh_pkg::tok_t in_tok,
	output logic          out_vld,
	output rbh_pkg::tok_t out_tok
);
	import rbh_pkg::*;

	localparam int HI_W = LO_W + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0] count_q;
	logic                  vld_q;
	tok_t                  tok_q;

	logic [LO_W-1:0]       end_ext;
	logic [HI_W-1:0]       hi_raw;
	logic [VALUE_W-1:0]    hi;
	logic                  exists;
	logic                  hit;
	logic                  sel;
	logic [COUNT_BITS-1:0] count_nx;
	tok_t                  tok_nx;

	always_comb begin
		end_ext  = LO_W'(cfg.range_end);
		exists   = (in_tok.lo <= end_ext);
		hi_raw   = HI_W'(in_tok.lo) + HI_W'(cfg.bin_width) - HI_W'(1);
		hi       = (hi_raw > HI_W'(cfg.range_end)) ? cfg.range_end : hi_raw[VALUE_W-1:0];
		hit      = exists && (in_tok.op == OP_ADD) &&
			(LO_W'(in_tok.sample) >= in_tok.lo) && (in_tok.sample <= hi);
		sel      = exists && (in_tok.op == OP_READ) &&
			(IDX_W'(in_tok.idx) == IDX_W'(CELL_IDX));
		count_nx = (hit && (count_q != CNT_MAX)) ? count_q + COUNT_BITS'(1) : count_q;

		tok_nx      = in_tok;
		tok_nx.lo   = in_tok.lo + LO_W'(cfg.bin_step);
		tok_nx.hits = in_tok.hits + TALLY_W'(hit);
		if (exists) begin
			if (COUNT_W'(count_nx) > in_tok.max_cnt) begin
				tok_nx.max_cnt = COUNT_W'(count_nx);
			end
			tok_nx.nz = in_tok.nz + TALLY_W'(count_nx != '0);
		end
		if (sel) begin
			tok_nx.rd_count  = COUNT_W'(count_q);
			tok_nx.rd_low    = in_tok.lo[VALUE_W-1:0];
			tok_nx.rd_high   = hi;
			tok_nx.rd_exists = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= in_vld;
			if (in_vld) begin
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nx;
	end

	assign out_vld = vld_q;
	assign out_tok = tok_q;

endmodule

### hdl/range_binned_histogram.sv
`timescale 1ns / 1ps
// A result is strobed on done when its command word leaves the last bin cell of the chain.
// Throughput: one command word per cycle; the chain of bin cells is fully pipelined.
// The figure is set by the chain, which moves each word one bin cell per cycle.
// Reset (arst_n low) clears every bin count and the valid bits of the chain, and loads the register defaults.
// The receiver cannot stall: each result word is valid for exactly one cycle.
module range_binned_histogram #(
	parameter int NUM_BINS   = rbh_pkg::NUM_BINS_DEF,
	parameter int VALUE_BITS = rbh_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = rbh_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  rbh_pkg::hist_in_t               cmd,
	output logic                            done,
	output rbh_pkg::hist_out_t              result,
	input  logic                            cfg_we,
	input  logic [rbh_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [rbh_pkg::VALUE_W-1:0]     cfg_data
);
	import rbh_pkg::*;

	// Values are carried on 16 bits; narrower values are masked down.
	localparam int VB = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam logic [VALUE_W-1:0] VMASK = VALUE_W'((64'd1 << VB) - 64'd1);

	cfg_t cfg_q;

	// Configuration registers. A step or width of zero behaves as one, so
	// it is stored as one and the cells never see zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_start <= RANGE_START_RST & VMASK;
			cfg_q.range_end   <= RANGE_END_RST & VMASK;
			cfg_q.bin_step    <= BIN_STEP_RST;
			cfg_q.bin_width   <= BIN_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_START: cfg_q.range_start <= cfg_data & VMASK;
				REG_RANGE_END:   cfg_q.range_end   <= cfg_data & VMASK;
				REG_BIN_STEP: begin
					cfg_q.bin_step <= (cfg_data == '0) ? VALUE_W'(1) : cfg_data;
				end
				REG_BIN_WIDTH: begin
					cfg_q.bin_width <= (cfg_data == '0) ? VALUE_W'(1) : cfg_data;
				end
				default: ;
			endcase
		end
	end

	// The chain. Position k of these arrays is the word entering cell k;
	// position NUM_BINS is the word leaving the last cell.
	logic vld [0:NUM_BINS];
	tok_t tok [0:NUM_BINS];

	// Every cycle can take a new word: a word only meets a bin after all
	// earlier words have updated it, so the chain never has to hold off.
	assign busy = 1'b0;

	// A fresh word starts at bin zero with the first bin start, empty
	// tallies and empty read fields. Each cell adds its own share as the
	// word passes, including the bin start of the next cell.
	always_comb begin
		vld[0]           = start && !busy;
		tok[0].op        = cmd.op;
		tok[0].sample    = cmd.sample_value & VMASK;
		tok[0].idx       = cmd.bin_index;
		tok[0].lo        = LO_W'(cfg_q.range_start);
		tok[0].hits      = '0;
		tok[0].max_cnt   = '0;
		tok[0].nz        = '0;
		tok[0].rd_count  = '0;
		tok[0].rd_low    = '0;
		tok[0].rd_high   = '0;
		tok[0].rd_exists = 1'b0;
	end

	for (genvar k = 0; k < NUM_BINS; k++) begin : g_bin
		rbh_cell #(
			.CELL_IDX  (k),
			.COUNT_BITS(COUNT_BITS)
		) u_bin (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.in_vld (vld[k]),
			.in_tok (tok[k]),
			.out_vld(vld[k+1]),
			.out_tok(tok[k+1])
		);
	end

	// The last cell's register is the result register. By the time a word
	// leaves it, the largest count and the nonzero tally cover every bin as
	// it stands after this word. Tallies are reported on seven bits.
	assign done                = vld[NUM_BINS];
	assign result.bin_count    = tok[NUM_BINS].rd_count;
	assign result.bin_low      = tok[NUM_BINS].rd_low;
	assign result.bin_high     = tok[NUM_BINS].rd_high;
	assign result.bin_exists   = tok[NUM_BINS].rd_exists;
	assign result.bins_hit     = tok[NUM_BINS].hits[HIT_W-1:0];
	assign result.max_count    = tok[NUM_BINS].max_cnt;
	assign result.nonzero_bins = tok[NUM_BINS].nz[HIT_W-1:0];

endmodule

### hdl/rbh_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbh_checker #(
	parameter int NUM_BINS = rbh_pkg::NUM_BINS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input rbh_pkg::hist_in_t  cmd,
	input logic               done,
	input rbh_pkg::hist_out_t result
);
	import rbh_pkg::*;

	// Each result belongs to a word taken earlier that has passed through the whole chain.
	`RBH_ASSERT_IMPL(a_done_after_word, clk, arst_n, done, $past(start && !busy, NUM_BINS), "result without a word taken a chain length before")

	// A read that missed every bin leaves the read fields empty.
	`RBH_ASSERT_IMPL(a_missing_bin_empty, clk, arst_n, done && !result.bin_exists, (result.bin_count == '0) && (result.bin_low == '0) && (result.bin_high == '0), "read fields set for a bin that does not exist")

	// An add increments bins and reads none; a read does the opposite.
	`RBH_ASSERT_IMPL(a_add_or_read, clk, arst_n, done && (result.bins_hit != '0), !result.bin_exists, "result carries both hits and a read bin")

	// A bin that exists never ends below its start.
	`RBH_ASSERT_IMPL(a_bounds_order, clk, arst_n, done && result.bin_exists, result.bin_low <= result.bin_high, "bin upper bound below its lower bound")

	// With no count above zero there is no occupied bin.
	`RBH_ASSERT_IMPL(a_empty_histogram, clk, arst_n, done && (result.max_count == '0), result.nonzero_bins == '0, "occupied bins reported with a largest count of zero")

endmodule

bind range_binned_histogram rbh_checker #(.NUM_BINS(NUM_BINS)) u_rbh_checker (.*);

### dv/hist_checker.sv
`timescale 1ns / 1ps

module hist_checker
	import rbh_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  hist_in_t               cmd,
	input  logic                   done,
	input  hist_out_t              result,
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [VALUE_W-1:0]     cfg_data,
	output int unsigned            errors,
	output int unsigned            pending
);

	localparam int BINS = NUM_BINS_DEF;

	// Shadow of the configuration registers and of the bin counts.
	logic [VALUE_W-1:0] rng_start, rng_end, step_cfg, width_cfg;
	logic [COUNT_W-1:0] bin_tally [BINS];
	hist_out_t          owed_results [$];
	int unsigned        fails = 0;

	assign errors = fails;

	// Bounds of one bin under the current settings; zero step or width counts as one.
	function automatic bit bin_span(input int unsigned idx, output logic [31:0] lo,
			output logic [31:0] hi);
		logic [31:0] st, wd;
		st = (step_cfg == '0) ? 32'd1 : 32'(step_cfg);
		wd = (width_cfg == '0) ? 32'd1 : 32'(width_cfg);
		lo = '0;
		hi = '0;
		if (idx >= BINS)
			return 1'b0;
		lo = 32'(rng_start) + idx * st;
		if (lo > 32'(rng_end)) begin
			lo = '0;
			return 1'b0;
		end
		hi = lo + wd - 32'd1;
		if (hi > 32'(rng_end))
			hi = 32'(rng_end);
		return 1'b1;
	endfunction

	// Applies one command word to the shadow counts and returns the word it must produce.
	function automatic hist_out_t tally_word(input hist_in_t w);
		hist_out_t   r;
		logic [31:0] lo, hi;
		logic [COUNT_W-1:0] peak;
		int unsigned hits, occupied;
		r = '0;
		hits = 0;
		peak = '0;
		occupied = 0;
		if (w.op == OP_ADD) begin
			for (int i = 0; i < BINS; i++) begin
				if (bin_span(i, lo, hi) && lo <= 32'(w.sample_value)
						&& 32'(w.sample_value) <= hi) begin
					if (bin_tally[i] != '1)
						bin_tally[i]++;
					hits++;
				end
			end
			r.bins_hit = HIT_W'(hits);
		end else if (bin_span(w.bin_index, lo, hi)) begin
			r.bin_count  = bin_tally[w.bin_index];
			r.bin_low    = VALUE_W'(lo);
			r.bin_high   = VALUE_W'(hi);
			r.bin_exists = 1'b1;
		end
		// Only bins that exist under the current settings take part in the scan.
		for (int i = 0; i < BINS; i++) begin
			if (bin_span(i, lo, hi)) begin
				if (bin_tally[i] > peak)
					peak = bin_tally[i];
				if (bin_tally[i] != '0)
					occupied++;
			end
		end
		r.max_count    = peak;
		r.nonzero_bins = HIT_W'(occupied);
		return r;
	endfunction

	function automatic void check_field(input string fname, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hist_out_t want;
		if (!arst_n) begin
			rng_start = RANGE_START_RST;
			rng_end   = RANGE_END_RST;
			step_cfg  = BIN_STEP_RST;
			width_cfg = BIN_WIDTH_RST;
			for (int i = 0; i < BINS; i++)
				bin_tally[i] = '0;
			owed_results.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (owed_results.size() == 0) begin
					fails++;
					$display("%0t: result word with nothing expected, actual %p", $time, result);
				end else begin
					want = owed_results.pop_front();
					check_field("bin_count", want.bin_count, result.bin_count);
					check_field("bin_low", want.bin_low, result.bin_low);
					check_field("bin_high", want.bin_high, result.bin_high);
					check_field("bin_exists", want.bin_exists, result.bin_exists);
					check_field("bins_hit", want.bins_hit, result.bins_hit);
					check_field("max_count", want.max_count, result.max_count);
					check_field("nonzero_bins", want.nonzero_bins, result.nonzero_bins);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_START: rng_start = cfg_data;
					REG_RANGE_END:   rng_end   = cfg_data;
					REG_BIN_STEP:    step_cfg  = cfg_data;
					REG_BIN_WIDTH:   width_cfg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				owed_results.insert(owed_results.size(), tally_word(cmd));
			pending <= owed_results.size();
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the range-binned histogram. The checker beside the block
// predicts every result word and counts mismatches; this module only drives words
// and configuration, and decides pass or fail once everything has drained.
module tb_top;
	import rbh_pkg::*;

	localparam int BINS        = NUM_BINS_DEF;
	localparam int PHASES      = 14;
	localparam int PHASE_WORDS = 132;
	// The slowest legal run is roughly 1900 words with the longest idle gaps between them plus a
	// drain per phase; the limit leaves a wide margin above that.
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	hist_in_t             cmd = '0;
	logic                 done;
	hist_out_t            result;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [VALUE_W-1:0]   cfg_data = '0;
	int unsigned          errors;
	int unsigned          pending;
	int unsigned          cycle_count = 0;

	// Current settings, kept here only to aim the random samples at existing bins.
	int unsigned cur_start = RANGE_START_RST;
	int unsigned cur_end   = RANGE_END_RST;
	int unsigned cur_step  = BIN_STEP_RST;
	int unsigned cur_width = BIN_WIDTH_RST;
	// When set, the sender never idles between words.
	bit          quiet_phase = 1'b0;

	always #5 clk = ~clk;

	range_binned_histogram dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hist_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// A run that hangs is a failure in its own right.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic hist_in_t add_word(input int unsigned value);
		hist_in_t w;
		w = '0;
		w.op = OP_ADD;
		w.sample_value = VALUE_W'(value);
		w.bin_index = BIN_INDEX_W'($urandom);
		return w;
	endfunction

	function automatic hist_in_t read_word(input int unsigned idx);
		hist_in_t w;
		w = '0;
		w.op = OP_READ;
		w.bin_index = BIN_INDEX_W'(idx);
		w.sample_value = VALUE_W'($urandom);
		return w;
	endfunction

	// Offers one word and returns at the edge where the block takes it. The caller is
	// always at such an edge (or idle), so start gets at most one assignment per step.
	task automatic issue(input hist_in_t w);
		int unsigned gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Holds the sender back until every expected result word has come out.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Writes all four registers on consecutive edges; only called while the block is idle.
	task automatic set_config(input logic [VALUE_W-1:0] s, input logic [VALUE_W-1:0] e,
			input logic [VALUE_W-1:0] st, input logic [VALUE_W-1:0] wd);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_RANGE_START;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= REG_RANGE_END;
		cfg_data  <= e;
		@(posedge clk);
		cfg_index <= REG_BIN_STEP;
		cfg_data  <= st;
		@(posedge clk);
		cfg_index <= REG_BIN_WIDTH;
		cfg_data  <= wd;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_start = 32'(s);
		cur_end   = 32'(e);
		cur_step  = (st == '0) ? 32'd1 : 32'(st);
		cur_width = (wd == '0) ? 32'd1 : 32'(wd);
	endtask

	// Random sample, mostly inside the span the bins cover so that adds actually land.
	function automatic int unsigned aimed_sample();
		int unsigned top;
		if (cur_start > cur_end || $urandom_range(0, 3) == 0)
			return $urandom_range(0, 65535);
		top = cur_start + BINS * cur_step + cur_width;
		if (top > cur_end)
			top = cur_end;
		return $urandom_range(cur_start, top);
	endfunction

	initial begin : stimulus
		logic [VALUE_W-1:0] s, e, st, wd;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings: 64 bins of four values from 0 to 255.
		// Edges of the first and last bins, values past the range end, and reads of the
		// first, last and several middle bins, with the unused field of each word randomized.
		issue(add_word(0));
		issue(add_word(3));
		issue(add_word(4));
		issue(add_word(252));
		issue(add_word(255));
		issue(add_word(256));
		issue(add_word(65535));
		issue(add_word(16'h5555));
		issue(add_word(16'h00AA));
		issue(add_word(16'hAAAA));
		issue(add_word(128));
		issue(add_word(128));
		issue(read_word(0));
		issue(read_word(1));
		issue(read_word(32));
		issue(read_word(62));
		issue(read_word(63));
		issue(read_word(21));
		issue(read_word(42));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			// The first phases walk through fixed corner settings: overlapping bins, the
			// widest step and width, a single bin at the top value, a start past the end
			// so that no bin exists, zero step and width, 64 bins all covering one value, wide
			// bins overlapping near the top value, and then the reset layout again with the old counts.
			case (p)
				0: set_config(16'd100, 16'd1000, 16'd3, 16'd10);
				1: set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: set_config(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
				3: set_config(16'd1000, 16'd500, 16'd7, 16'd7);
				4: set_config(16'd200, 16'd300, 16'd0, 16'd0);
				5: set_config(16'd0, 16'hFFFF, 16'd1, 16'd64);
				6: set_config(16'd40000, 16'hFFFF, 16'd1000, 16'd2000);
				7: set_config(RANGE_START_RST, RANGE_END_RST, BIN_STEP_RST, BIN_WIDTH_RST);
				default: begin
					s  = $urandom;
					e  = ($urandom_range(0, 4) == 0) ? VALUE_W'($urandom)
						: VALUE_W'((32'(s) + $urandom_range(0, 2000) > 65535) ? 65535
						: 32'(s) + $urandom_range(0, 2000));
					st = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom)
						: VALUE_W'($urandom_range(1, 40));
					wd = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom)
						: VALUE_W'($urandom_range(1, 80));
					set_config(s, e, st, wd);
				end
			endcase
			quiet_phase = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if ($urandom_range(0, 3) == 0)
					issue(read_word($urandom_range(0, BINS - 1)));
				else
					issue(add_word(aimed_sample()));
			end
		end

		drain();
		repeat (BINS + 16) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
